// ===== hw/rtl/pes_pkg.sv =====
package pes_pkg;

  // Width of the tick counter and of every period register.
  localparam int unsigned CountWidth = 16;
  // Number of period registers that exist, independent of the channel count.
  localparam int unsigned PeriodRegs = 4;
  localparam int unsigned ChanIdxWidth = $clog2(PeriodRegs);
  localparam int unsigned ActiveWidth = 3;
  localparam int unsigned BitIdxWidth = $clog2(CountWidth);
  localparam int unsigned CfgIdxWidth = 3;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [PeriodRegs-1:0] mask_t;
  typedef logic [ActiveWidth-1:0] active_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  // Register indexes on the configuration channel.
  localparam cfg_idx_t CfgActive  = 3'd0;
  localparam cfg_idx_t CfgPeriod0 = 3'd1;
  localparam cfg_idx_t CfgPeriod1 = 3'd2;
  localparam cfg_idx_t CfgPeriod2 = 3'd3;
  localparam cfg_idx_t CfgPeriod3 = 3'd4;

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StDone
  } state_e;

endpackage

// ===== hw/rtl/pes_if.sv =====
interface pes_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface pes_result_if;
  logic                valid;
  logic                ready;
  pes_pkg::count_t     time_now;
  pes_pkg::mask_t      fire_mask;

  modport source (output valid, output time_now, output fire_mask, input ready);
  modport sink (input valid, input time_now, input fire_mask, output ready);
endinterface

interface pes_cfg_if;
  logic                valid;
  logic                ready;
  pes_pkg::cfg_idx_t   index;
  pes_pkg::count_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/periodic_event_scheduler_unit.sv =====
// An item with tick = 0, or with no live channel, goes straight to the done state; an
// item with tick = 1 first walks the live channels in the divide state. No new item is
// taken until the last leaves the done state, which waits for a free output register.
// The single restoring divider step works one bit of the count per cycle.
// Reset (rst_ni low, asynchronous) clears the counter, the configuration registers,
// the sequencer state and the output valid; the per-item working registers load on accept.
module periodic_event_scheduler_unit #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  pes_tick_if.sink     tick_i,
  pes_cfg_if.sink      cfg_i,
  pes_result_if.source result_o
);
  import pes_pkg::*;

  // Saturation limit of the active channel count. Only channels that own a
  // period register can ever fire, so the sequencer also stops at PeriodRegs.
  localparam active_t ChanLim = ActiveWidth'(CHANNELS);
  localparam active_t RegLim  = ActiveWidth'(PeriodRegs);

  // Configuration registers. The channel is always ready. Writes must be made only
  // while the block is idle, or they race the sequencer; the block does not enforce it.
  active_t active_q;
  count_t  period_q [PeriodRegs];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < PeriodRegs; i++) begin
        period_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgActive:  active_q    <= cfg_i.data[ActiveWidth-1:0];
        CfgPeriod0: period_q[0] <= cfg_i.data;
        CfgPeriod1: period_q[1] <= cfg_i.data;
        CfgPeriod2: period_q[2] <= cfg_i.data;
        CfgPeriod3: period_q[3] <= cfg_i.data;
        default: ;  // Unknown indexes are ignored.
      endcase
    end
  end

  // Number of channels the sequencer walks for a tick: the active count,
  // saturated at the channel capacity and at the number of period registers.
  active_t live_sat;
  active_t live_cnt;
  always_comb begin
    live_sat = (active_q > ChanLim) ? ChanLim : active_q;
    live_cnt = (live_sat > RegLim) ? RegLim : live_sat;
  end

  // Sequencer state and datapath registers.
  state_e                   state_q, state_d;
  count_t                   count_q;
  active_t                  n_live_q;
  logic [ChanIdxWidth-1:0]  ch_q;
  logic [BitIdxWidth-1:0]   bit_q;
  count_t                   rem_q;
  mask_t                    mask_q;

  logic    out_valid_q;
  count_t  out_time_q;
  mask_t   out_mask_q;

  // Shared divider step. The remainder of count / period is built MSB first:
  // shift in the next count bit, subtract the period when it fits. After all
  // 16 bits rem holds count % period. A zero period is masked off below.
  count_t             per_sel;
  logic [CountWidth:0] rem_shift;
  logic                rem_fits;
  logic [CountWidth:0] rem_sub;
  count_t              rem_next;

  always_comb begin
    per_sel   = period_q[ch_q];
    rem_shift = {rem_q, count_q[bit_q]};
    rem_fits  = rem_shift >= {1'b0, per_sel};
    rem_sub   = rem_shift - {1'b0, per_sel};
    rem_next  = rem_fits ? rem_sub[CountWidth-1:0] : rem_shift[CountWidth-1:0];
  end

  logic in_acc;
  logic last_bit;
  logic last_ch;
  logic out_free;
  logic start_div;
  logic finish;

  assign in_acc   = tick_i.valid && tick_i.ready;
  assign last_bit = (bit_q == '0);
  assign last_ch  = ({1'b0, ch_q} == (n_live_q - active_t'(1)));
  assign out_free = !out_valid_q || result_o.ready;
  assign start_div = tick_i.tick && (live_cnt != '0);

  // Next state and handshake outputs.
  always_comb begin
    state_d      = state_q;
    tick_i.ready = 1'b0;
    finish       = 1'b0;
    case (state_q)
      StIdle: begin
        tick_i.ready = 1'b1;
        if (tick_i.valid) begin
          state_d = start_div ? StDivide : StDone;
        end
      end
      StDivide: begin
        if (last_bit && last_ch) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          finish  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc && tick_i.tick) begin
        count_q <= count_q + count_t'(1);
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      n_live_q <= live_cnt;
      ch_q     <= '0;
      bit_q    <= BitIdxWidth'(CountWidth - 1);
      rem_q    <= '0;
      mask_q   <= '0;
    end else if (state_q == StDivide) begin
      if (last_bit) begin
        mask_q[ch_q] <= (rem_next == '0) && (per_sel != '0);
        rem_q        <= '0;
        bit_q        <= BitIdxWidth'(CountWidth - 1);
        ch_q         <= ch_q + ChanIdxWidth'(1);
      end else begin
        rem_q <= rem_next;
        bit_q <= bit_q - BitIdxWidth'(1);
      end
    end
  end

  // Output register: it holds a finished item until the sink takes it, so
  // the next tick can already be accepted and worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_time_q <= count_q;
      out_mask_q <= mask_q;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.time_now  = out_time_q;
  assign result_o.fire_mask = out_mask_q;

`ifndef SYNTHESIS
  // An item without a tick must not move the counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !tick_i.tick) |=> $stable(count_q))
    else $error("counter moved on an item without tick");

  // The partial remainder is always reduced below a nonzero period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide && per_sel != '0) |-> (rem_q < per_sel))
    else $error("divider remainder not reduced");

  // The sequencer never walks past the live channels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide) |-> ({1'b0, ch_q} < n_live_q))
    else $error("channel index beyond live count");

  // Leaving the done state always presents a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> result_o.valid)
    else $error("finished item not presented");
`endif

endmodule

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pes_pkg::*;

  // Channel count the block is built with. Period registers exist for the first
  // PeriodRegs channels only; the active count saturates at this value.
  localparam int Chans = 4;
  localparam int DrainCycles = 16 * PeriodRegs + 16;
  localparam int MaxShown = 30;
  // The slowest correct run is well under 10 ms; this leaves a wide margin.
  localparam int TimeoutNs = 60_000_000;
  localparam int RandomItems = 1150;
  localparam count_t WrapStart = 16'd65528;

  typedef struct packed {
    count_t time_now;
    mask_t  fire_mask;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pes_tick_if   tick_ch ();
  pes_cfg_if    cfg_ch ();
  pes_result_if res_ch ();

  periodic_event_scheduler_unit #(
    .CHANNELS(Chans)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_ch),
    .cfg_i   (cfg_ch),
    .result_o(res_ch)
  );

  always #10 clk_i = ~clk_i;

  // Scheduler state as the testbench predicts it. It moves forward at the
  // clock edge where the block accepts an item or a register write.
  count_t  model_count = '0;
  active_t model_active = '0;
  count_t  model_period [PeriodRegs] = '{default: '0};

  // Expected results in the order the block must deliver them.
  sched_result_t expected_results [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int fired_results = 0;
  int reg_writes = 0;

  // Handshake between the tests and the result drain process: a nonzero
  // hold_request makes the drain hold ready low for that many cycles, and
  // drain_steady keeps ready high for fast stretches of the run.
  int hold_request = 0;
  bit drain_steady = 1'b0;

  // One tick item: advance the counter if asked, then test each live channel
  // for a period boundary. A zero period never fires.
  function automatic sched_result_t advance_schedule(logic tick);
    sched_result_t res;
    int live;
    res.fire_mask = '0;
    if (tick) begin
      model_count = model_count + 1'b1;
      live = (int'(model_active) > Chans) ? Chans : int'(model_active);
      for (int ch = 0; ch < PeriodRegs; ch++) begin
        if (ch < live && model_period[ch] != '0 && (model_count % model_period[ch]) == '0) begin
          res.fire_mask[ch] = 1'b1;
        end
      end
    end
    res.time_now = model_count;
    return res;
  endfunction

  // Register writes to an index past the last period register change nothing.
  function automatic void apply_reg_write(cfg_idx_t idx, count_t data);
    if (idx == CfgActive) begin
      model_active = data[ActiveWidth-1:0];
    end else if (idx >= CfgPeriod0 && idx <= CfgPeriod3) begin
      model_period[idx - CfgPeriod0] = data;
    end
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= MaxShown) begin
      $display("%0t: %s", $time, msg);
    end else if (errors == MaxShown + 1) begin
      $display("%0t: further mismatches are not shown", $time);
    end
  endfunction

  // Period values weighted toward small ones so that channels fire often,
  // with zero, one and the largest period mixed in.
  function automatic count_t pick_period();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return '0;
    if (pick < 3) return 16'd1;
    if (pick < 13) return count_t'($urandom_range(2, 12));
    if (pick < 17) return count_t'($urandom_range(13, 300));
    if (pick < 19) return count_t'($urandom);
    return 16'hFFFF;
  endfunction

  // Offers one item and waits for the edge that takes it. Valid stays high
  // afterwards so that the next item can follow without a bubble; whoever
  // pauses or drains lowers it.
  task automatic send_tick(logic tick);
    tick_ch.valid <= 1'b1;
    tick_ch.tick  <= tick;
    do @(posedge clk_i); while (!tick_ch.ready);
    expected_results.push_back(advance_schedule(tick));
    items_sent++;
  endtask

  // Sends count items, tick = 1 with the given percentage. With gappy set,
  // the items come in bursts of random length separated by random gaps; a
  // zero gap merges two bursts into a longer stretch without idling.
  task automatic send_stream(int count, int tick_pct, bit gappy);
    int burst_left;
    int gap;
    burst_left = 0;
    repeat (count) begin
      if (gappy && burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 12);
        if (gap > 0) begin
          tick_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      if (burst_left > 0) burst_left--;
      send_tick($urandom_range(0, 99) < tick_pct);
    end
  endtask

  // Stops offering items and waits until every expected result is back, so
  // that the block is idle.
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(cfg_idx_t idx, count_t data);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    apply_reg_write(idx, data);
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_periods(count_t p0, count_t p1, count_t p2, count_t p3);
    write_reg(CfgPeriod0, p0);
    write_reg(CfgPeriod1, p1);
    write_reg(CfgPeriod2, p2);
    write_reg(CfgPeriod3, p3);
  endtask

  // Out of reset no channel is active. Ticks without a tick bit only report
  // the count. Then all four channels go live with zero periods, which must
  // never fire.
  task automatic test_after_reset();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    write_reg(CfgActive, 16'd4);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Small periods on all channels give overlapping fire patterns, with
  // no-tick items in between that must fire nothing.
  task automatic test_fire_patterns();
    write_periods(16'd1, 16'd2, 16'd3, 16'd4);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // With every period at one, the fire mask shows exactly which channels are
  // live. An active count above the channel count must saturate, and the
  // upper data bits of the active register write must be dropped.
  task automatic test_channel_limit();
    write_periods(16'd1, 16'd1, 16'd1, 16'd1);
    write_reg(CfgActive, 16'hFFFF);
    send_tick(1'b1);
    write_reg(CfgActive, 16'hFFF3);
    send_tick(1'b1);
    write_reg(CfgActive, 16'd1);
    send_tick(1'b1);
    write_reg(CfgActive, 16'd0);
    send_tick(1'b1);
  endtask

  // Writes to the indexes past the last period register must not alias onto
  // any real register: zero data there would silence the channels.
  task automatic test_unknown_index();
    write_reg(CfgActive, 16'd4);
    for (int k = 1; k <= 3; k++) begin
      write_reg(cfg_idx_t'(CfgPeriod3 + k), 16'h0000);
    end
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // The drain holds ready low for a long stretch while items keep coming,
  // so the block fills up and has to stall its input.
  task automatic test_output_stall();
    write_periods(16'd2, 16'd3, 16'd5, 16'd7);
    hold_request = 400;
    send_stream(12, 100, 1'b0);
    wait_drained();
  endtask

  // Phases of random register settings, each followed by a random stream.
  // The active count sometimes carries random upper data bits, and now and
  // then an unused index is written.
  task automatic test_random_schedules();
    int sent;
    int phase_len;
    count_t data;
    sent = 0;
    while (sent < RandomItems) begin
      data = count_t'($urandom);
      data[ActiveWidth-1:0] = ($urandom_range(0, 3) == 0) ? active_t'($urandom_range(0, 7))
                                                          : active_t'(Chans);
      write_reg(CfgActive, data);
      for (int k = 0; k < PeriodRegs; k++) begin
        if ($urandom_range(0, 3) != 0) write_reg(cfg_idx_t'(CfgPeriod0 + k), pick_period());
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(cfg_idx_t'(CfgPeriod3 + $urandom_range(1, 3)), count_t'($urandom));
      end
      phase_len = $urandom_range(30, 70);
      send_stream(phase_len, 80, 1'b1);
      sent += phase_len;
    end
  endtask

  // Runs the counter up to just below the wrap with no live channel, which
  // is the fastest path through the block, then crosses 65535 -> 0 with
  // periods chosen so that the largest period fires at 65535 and every
  // channel fires at zero.
  task automatic test_counter_wrap();
    write_reg(CfgActive, 16'd0);
    drain_steady = 1'b1;
    send_stream(int'(count_t'(WrapStart - model_count)), 100, 1'b0);
    wait_drained();
    drain_steady = 1'b0;
    write_periods(16'hFFFF, 16'd2, 16'd5, 16'd8);
    write_reg(CfgActive, 16'd4);
    send_stream(14, 100, 1'b1);
    send_stream(10, 70, 1'b1);
  endtask

  // Result drain. Ready follows a pattern of its own that changes mode after each
  // random stretch: always ready, random, or ready one cycle in four. A hold
  // request from a test overrides the pattern.
  initial begin : result_drain
    int held;
    int mode;
    int stretch;
    int unsigned beat;
    held = 0;
    mode = 0;
    stretch = 0;
    beat = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      beat++;
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
      end
      if (held > 0) begin
        held--;
        res_ch.ready <= 1'b0;
      end else if (drain_steady) begin
        res_ch.ready <= 1'b1;
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 2);
          stretch = $urandom_range(10, 80);
        end
        stretch--;
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          default: res_ch.ready <= ((beat % 4) == 0);
        endcase
      end
    end
  end

  // Every result taken by the drain is compared with the oldest expectation.
  // Signals are read as they stood before the edge.
  always @(posedge clk_i) begin : check_results
    sched_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (res_ch.fire_mask != '0) fired_results++;
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result with none expected: time_now %h fire_mask %b",
                             res_ch.time_now, res_ch.fire_mask));
      end else begin
        want = expected_results.pop_front();
        if (res_ch.time_now !== want.time_now) begin
          flag_error($sformatf("time_now mismatch: expected %h actual %h",
                               want.time_now, res_ch.time_now));
        end
        if (res_ch.fire_mask !== want.fire_mask) begin
          flag_error($sformatf("fire_mask mismatch at count %h: expected %b actual %b",
                               want.time_now, want.fire_mask, res_ch.fire_mask));
        end
      end
    end
  end

  initial begin : run_tests
    tick_ch.valid = 1'b0;
    tick_ch.tick  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CfgActive;
    cfg_ch.data   = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_fire_patterns();
    test_channel_limit();
    test_unknown_index();
    test_output_stall();
    test_random_schedules();
    test_counter_wrap();

    // Let any stray result show up before the verdict.
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d tick items and %0d register writes; checked %0d results, %0d with firing.",
             items_sent, reg_writes, results_seen, fired_results);
    $display("Covered reset state, zero periods, saturation, unused indexes, stalls, wrap.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/pes_pkg.sv
hw/rtl/pes_if.sv
hw/rtl/periodic_event_scheduler_unit.sv
tb/testbench.sv
